/* sv/rrtu_pkg.sv */
// rrtu_pkg: shared types, constants and outcome codes of the rip route table update unit
// no dependencies; compiled first
`default_nettype none

package rrtu_pkg;

	// defaults for the top-level parameters
	localparam int DEF_TABLE_DEPTH = 64;
	localparam int DEF_MAX_MESSAGE_ENTRIES = 25;

	// message entry counter saturates at its all-ones value
	localparam int COUNT_W = 5;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

	localparam logic [15:0] RIP_FAMILY_IP = 16'd2;
	localparam logic [4:0] METRIC_INF = 5'd16;
	localparam logic [4:0] METRIC_STEP = 5'd1;

	typedef enum logic [3:0] {
		OC_BAD_FAMILY  = 4'd0,
		OC_BAD_METRIC  = 4'd1,
		OC_OVER_LIMIT  = 4'd2,
		OC_ADDED       = 4'd3,
		OC_TABLE_FULL  = 4'd4,
		OC_UNREACH_NEW = 4'd5,
		OC_CHANGED     = 4'd6,
		OC_REFRESHED   = 4'd7,
		OC_WORSE       = 4'd8
	} outcome_t;

	typedef struct packed {
		logic [15:0] address_family;
		logic [31:0] dest_ip;
		logic [31:0] dest_mask;
		logic [31:0] entry_gateway;
		logic [31:0] rx_metric;
		logic [31:0] sender_ip;
		logic [31:0] now_time;
		logic        last_of_message;
	} entry_beat_t;

	typedef struct packed {
		outcome_t    outcome;
		logic [5:0]  route_slot;
		logic        message_changed;
		logic        last_result;
	} result_beat_t;

	// one stored route
	typedef struct packed {
		logic [31:0] dest;
		logic [31:0] mask;
		logic [31:0] gateway;
		logic [4:0]  metric;
		logic [31:0] updated_time;
		logic        garbage;
	} route_entry_t;

	// verdict of the front-end checks on one beat
	typedef struct packed {
		logic        bad;
		outcome_t    oc;
		logic [4:0]  metric;
		logic [31:0] gateway;
	} screen_t;

endpackage

`default_nettype wire

/* sv/rrtu_if.sv */
// rrtu_if: valid/ready channels for route entry beats and result beats
// depends on rrtu_pkg
`default_nettype none

interface rrtu_entry_if import rrtu_pkg::*; ();
	logic        valid;
	logic        ready;
	entry_beat_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface rrtu_result_if import rrtu_pkg::*; ();
	logic         valid;
	logic         ready;
	result_beat_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* sv/rrtu_screen.sv */
// rrtu_screen: message limit, family and metric checks, metric increment, gateway choice
// depends on rrtu_pkg
`default_nettype none

module rrtu_screen import rrtu_pkg::*; #(
	parameter int MAX_MESSAGE_ENTRIES = DEF_MAX_MESSAGE_ENTRIES
) (
	input  wire entry_beat_t        beat,
	input  wire logic [COUNT_W-1:0] count,
	output screen_t                 verdict
);

	localparam logic [COUNT_W-1:0] MAX_ENTRIES = COUNT_W'(MAX_MESSAGE_ENTRIES);

	logic metric_bad;

	assign metric_bad = (beat.rx_metric == 32'd0) ||
		(beat.rx_metric > 32'(METRIC_INF));

	always_comb begin
		verdict.bad = 1'b1;
		verdict.oc  = OC_OVER_LIMIT;
		priority if (count >= MAX_ENTRIES) begin
			verdict.oc = OC_OVER_LIMIT;
		end else if (beat.address_family != RIP_FAMILY_IP) begin
			verdict.oc = OC_BAD_FAMILY;
		end else if (metric_bad) begin
			verdict.oc = OC_BAD_METRIC;
		end else begin
			verdict.bad = 1'b0;
			verdict.oc  = OC_ADDED;
		end
		// one hop further, capped at infinity
		if (beat.rx_metric[4:0] == METRIC_INF) begin
			verdict.metric = METRIC_INF;
		end else begin
			verdict.metric = beat.rx_metric[4:0] + METRIC_STEP;
		end
		verdict.gateway = (beat.entry_gateway == 32'd0) ? beat.sender_ip : beat.entry_gateway;
	end

endmodule

`default_nettype wire

/* sv/rrtu_mem.sv */
// rrtu_mem: route store, one write port and one read port with registered read data
// depends on rrtu_pkg
`default_nettype none

module rrtu_mem import rrtu_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             rd_en,
	input  wire logic [IDX_W-1:0] rd_addr,
	output route_entry_t          rd_data,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_addr,
	input  wire route_entry_t     wr_data
);

	route_entry_t store [TABLE_DEPTH];
	route_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= store[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

/* sv/rrtu_ctrl.sv */
// rrtu_ctrl: scan sequencer, read-modify-write decision, message counters, result register
// depends on rrtu_pkg; drives rrtu_mem and takes the verdict of rrtu_screen
`default_nettype none

module rrtu_ctrl import rrtu_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	localparam int IDX_W = $clog2(TABLE_DEPTH),
	localparam int FILL_W = $clog2(TABLE_DEPTH + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             entry_valid,
	output logic                  entry_ready,
	input  wire entry_beat_t      entry_beat,
	input  wire screen_t          verdict,
	output logic [COUNT_W-1:0]    count,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output result_beat_t          result_beat,
	output logic                  rd_en,
	output logic [IDX_W-1:0]      rd_addr,
	input  wire route_entry_t     rd_data,
	output logic                  wr_en,
	output logic [IDX_W-1:0]      wr_addr,
	output route_entry_t          wr_data
);

	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(TABLE_DEPTH);
	localparam logic [FILL_W-1:0] FILL_ONE = FILL_W'(1);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DECIDE} state_t;

	typedef struct packed {
		logic [31:0] dest;
		logic [31:0] mask;
		logic [31:0] now;
		logic        last;
		screen_t     sv;
	} work_t;

	state_t            state_q;
	work_t             item_q;
	logic [FILL_W-1:0] addr_q;
	logic [FILL_W-1:0] fill_q;
	logic              pend_s1;
	logic [IDX_W-1:0]  pend_idx_s1;
	logic              found_q;
	logic [IDX_W-1:0]  hit_q;
	route_entry_t      hit_entry_q;
	logic [COUNT_W-1:0] count_q;
	logic              acc_q;
	logic              out_valid_q;
	result_beat_t      out_beat_q;

	logic             match;
	logic             out_free;
	logic             wr_want;
	logic             changed;
	logic             adding;
	outcome_t         oc;
	logic [IDX_W-1:0] slot_idx;
	logic [IDX_W+5:0] slot_ext;

	assign entry_ready  = (state_q == ST_IDLE);
	assign result_valid = out_valid_q;
	assign result_beat  = out_beat_q;
	assign count        = count_q;
	assign out_free     = !out_valid_q || result_ready;

	// sequential read of the filled part of the table
	assign rd_en   = (state_q == ST_SCAN) && (addr_q < fill_q);
	assign rd_addr = addr_q[IDX_W-1:0];
	assign match   = pend_s1 && (rd_data.dest == item_q.dest) && (rd_data.mask == item_q.mask);

	always_comb begin
		oc       = item_q.sv.oc;
		slot_idx = '0;
		wr_want  = 1'b0;
		changed  = 1'b0;
		adding   = 1'b0;
		wr_addr  = hit_q;
		wr_data  = hit_entry_q;
		priority if (item_q.sv.bad) begin
			oc = item_q.sv.oc;
		end else if (!found_q) begin
			priority if (item_q.sv.metric >= METRIC_INF) begin
				oc = OC_UNREACH_NEW;
			end else if (fill_q == FILL_FULL) begin
				oc = OC_TABLE_FULL;
			end else begin
				oc                   = OC_ADDED;
				adding               = 1'b1;
				wr_want              = 1'b1;
				changed              = 1'b1;
				slot_idx             = fill_q[IDX_W-1:0];
				wr_addr              = fill_q[IDX_W-1:0];
				wr_data.dest         = item_q.dest;
				wr_data.mask         = item_q.mask;
				wr_data.gateway      = item_q.sv.gateway;
				wr_data.metric       = item_q.sv.metric;
				wr_data.updated_time = item_q.now;
				wr_data.garbage      = 1'b0;
			end
		end else begin
			slot_idx = hit_q;
			priority if (hit_entry_q.gateway == item_q.sv.gateway) begin
				// same router: refresh, follow its metric, garbage at infinity
				changed = (hit_entry_q.metric != item_q.sv.metric) ||
					((item_q.sv.metric == METRIC_INF) && !hit_entry_q.garbage);
				wr_want              = 1'b1;
				wr_data.metric       = item_q.sv.metric;
				wr_data.updated_time = item_q.now;
				wr_data.garbage      = (item_q.sv.metric == METRIC_INF);
				oc                   = changed ? OC_CHANGED : OC_REFRESHED;
			end else if (item_q.sv.metric < hit_entry_q.metric) begin
				wr_want              = 1'b1;
				changed              = 1'b1;
				wr_data.metric       = item_q.sv.metric;
				wr_data.gateway      = item_q.sv.gateway;
				wr_data.updated_time = item_q.now;
				wr_data.garbage      = 1'b0;
				oc                   = OC_CHANGED;
			end else begin
				oc = OC_WORSE;
			end
		end
		wr_en = wr_want && (state_q == ST_DECIDE) && out_free;
	end

	assign slot_ext = {6'b0, slot_idx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			item_q      <= '0;
			addr_q      <= '0;
			fill_q      <= '0;
			pend_s1     <= 1'b0;
			pend_idx_s1 <= '0;
			found_q     <= 1'b0;
			hit_q       <= '0;
			hit_entry_q <= '0;
			count_q     <= '0;
			acc_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_beat_q  <= '0;
		end else begin
			// result register: loaded on a decision, emptied when taken
			if ((state_q == ST_DECIDE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					pend_s1 <= 1'b0;
					if (entry_valid) begin
						item_q.dest <= entry_beat.dest_ip;
						item_q.mask <= entry_beat.dest_mask;
						item_q.now  <= entry_beat.now_time;
						item_q.last <= entry_beat.last_of_message;
						item_q.sv   <= verdict;
						addr_q      <= '0;
						found_q     <= 1'b0;
						state_q     <= verdict.bad ? ST_DECIDE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					pend_s1     <= rd_en && !match;
					pend_idx_s1 <= rd_addr;
					if (rd_en) begin
						addr_q <= addr_q + FILL_ONE;
					end
					if (match) begin
						found_q     <= 1'b1;
						hit_q       <= pend_idx_s1;
						hit_entry_q <= rd_data;
						state_q     <= ST_DECIDE;
					end else if (!pend_s1 && !rd_en) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					pend_s1 <= 1'b0;
					if (out_free) begin
						out_beat_q.outcome         <= oc;
						out_beat_q.route_slot      <= slot_ext[5:0];
						out_beat_q.message_changed <= acc_q | changed;
						out_beat_q.last_result     <= item_q.last;
						if (adding) begin
							fill_q <= fill_q + FILL_ONE;
						end
						if (item_q.last) begin
							count_q <= '0;
							acc_q   <= 1'b0;
						end else begin
							if (count_q != COUNT_MAX) begin
								count_q <= count_q + COUNT_W'(1);
							end
							acc_q <= acc_q | changed;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* sv/rip_route_table_update_unit.sv */
// rip_route_table_update_unit: top level of the rip v2 route table update
// depends on rrtu_pkg, rrtu_if, rrtu_screen, rrtu_mem and rrtu_ctrl
`default_nettype none

// Takes one route entry of a rip v2 response per beat on the entry channel and
// gives one result beat per entry on the result channel. An entry beat is first
// screened (message limit, then family, then metric); a screened-out entry skips
// the scan and goes straight to the decision. Any other entry is looked up by
// exact destination and mask with a sequential scan of the route memory, one
// entry read per cycle through its single read port; the scan stops at the first
// hit or after the last filled slot, so a miss reads every filled slot. Routes
// are never removed, so the filled slots are always a prefix of the table and a
// fill count stands in for per-slot valid bits: no clearing pass runs after
// reset and the table is usable at once. The matching slot is then modified
// and written back before the next entry is accepted, so reads and writes of
// one slot never overlap. One entry is worked on at a time; the result sits in
// an output register, and the next entry is taken while it waits there; a
// result still held there when the next decision is due stalls the unit for as
// long as it waits. The message counter and the changed flag return to zero
// after the result of an entry marked last of its message.
module rip_route_table_update_unit import rrtu_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int MAX_MESSAGE_ENTRIES = DEF_MAX_MESSAGE_ENTRIES
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	rrtu_entry_if.sink  entry,
	rrtu_result_if.source result
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	// screen verdict for the beat at the entry port
	screen_t            verdict;
	logic [COUNT_W-1:0] count;

	// memory port
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	route_entry_t     rd_data;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	route_entry_t     wr_data;

	rrtu_screen #(
		.MAX_MESSAGE_ENTRIES(MAX_MESSAGE_ENTRIES)
	) u_screen (
		.beat    (entry.payload),
		.count   (count),
		.verdict (verdict)
	);

	rrtu_mem #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// sequencer: scan, decide, write back, result register
	rrtu_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.entry_valid  (entry.valid),
		.entry_ready  (entry.ready),
		.entry_beat   (entry.payload),
		.verdict      (verdict),
		.count        (count),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.result_beat  (result.payload),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data)
	);

endmodule

`default_nettype wire

/* sv/rrtu_checker.sv */
// rrtu_checker: port-level assertions for rip_route_table_update_unit, with its bind
// depends on rrtu_pkg; bound to the top level
`default_nettype none

module rrtu_checker import rrtu_pkg::*; (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         entry_valid,
	input wire logic         entry_ready,
	input wire logic         result_valid,
	input wire logic         result_ready,
	input wire result_beat_t result_beat
);

	// stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_beat))
		else $error("result beat dropped or changed while stalled");

	// one entry in flight: no beat accepted right after another
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		entry_valid && entry_ready |=> !entry_ready)
		else $error("entry accepted while the previous one is in work");

	// entries that touch no slot report slot zero
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_beat.outcome == OC_BAD_FAMILY ||
		result_beat.outcome == OC_BAD_METRIC || result_beat.outcome == OC_OVER_LIMIT ||
		result_beat.outcome == OC_TABLE_FULL || result_beat.outcome == OC_UNREACH_NEW)
		|-> result_beat.route_slot == 6'd0)
		else $error("slot reported for an entry that touched no slot");

	// a change to the table shows in the message flag
	a_change_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_beat.outcome == OC_ADDED ||
		result_beat.outcome == OC_CHANGED) |-> result_beat.message_changed)
		else $error("table changed but message flag clear");

endmodule

bind rip_route_table_update_unit rrtu_checker u_rrtu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.entry_valid  (entry.valid),
	.entry_ready  (entry.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_beat  (result.payload)
);

`default_nettype wire

/* test/rrtu_mirror_pkg.sv */
// rrtu_mirror_pkg: scoreboard class that mirrors the route table and checks result beats
// depends on rrtu_pkg
`timescale 1ns / 1ps

package rrtu_mirror_pkg;
	import rrtu_pkg::*;

	class route_table_mirror;
		int unsigned depth;
		int unsigned msg_limit;

		// mirrored routes; update time is not observable and is not kept
		bit          slot_used [];
		logic [31:0] slot_dest [];
		logic [31:0] slot_mask [];
		logic [31:0] slot_hop [];
		logic [4:0]  slot_metric [];
		bit          slot_garbage [];

		logic [COUNT_W-1:0] entry_count;
		bit                 changed_acc;

		result_beat_t pending_outcomes [$];

		int unsigned faults;
		int unsigned checked;
		int unsigned outcome_seen [16];

		function new(int unsigned d, int unsigned lim);
			depth = d;
			msg_limit = lim;
			slot_used = new[d];
			slot_dest = new[d];
			slot_mask = new[d];
			slot_hop = new[d];
			slot_metric = new[d];
			slot_garbage = new[d];
			foreach (slot_used[i]) slot_used[i] = 1'b0;
			entry_count = '0;
			changed_acc = 1'b0;
			faults = 0;
			checked = 0;
			foreach (outcome_seen[i]) outcome_seen[i] = 0;
		endfunction

		// apply one entry to the mirrored table and give the result it should cause
		function result_beat_t apply_entry(entry_beat_t e);
			result_beat_t r;
			logic [31:0]  raised;
			logic [31:0]  gw;
			logic [4:0]   m;
			bit           over;
			bit           found;
			bit           has_free;
			bit           changed;
			int           hit;
			int           free_slot;
			over = (entry_count >= msg_limit);
			found = 1'b0;
			has_free = 1'b0;
			changed = 1'b0;
			hit = 0;
			free_slot = 0;
			if (entry_count < COUNT_MAX)
				entry_count++;
			r.route_slot = '0;
			if (over) begin
				r.outcome = OC_OVER_LIMIT;
			end else if (e.address_family != RIP_FAMILY_IP) begin
				r.outcome = OC_BAD_FAMILY;
			end else if (e.rx_metric < 32'd1 || e.rx_metric > 32'(METRIC_INF)) begin
				r.outcome = OC_BAD_METRIC;
			end else begin
				raised = e.rx_metric + 32'(METRIC_STEP);
				m = (raised > 32'(METRIC_INF)) ? METRIC_INF : raised[4:0];
				gw = (e.entry_gateway == '0) ? e.sender_ip : e.entry_gateway;
				for (int i = 0; i < int'(depth); i++) begin
					if (slot_used[i]) begin
						if (!found && slot_dest[i] == e.dest_ip && slot_mask[i] == e.dest_mask) begin
							found = 1'b1;
							hit = i;
						end
					end else if (!has_free) begin
						has_free = 1'b1;
						free_slot = i;
					end
				end
				if (!found) begin
					if (m >= METRIC_INF) begin
						r.outcome = OC_UNREACH_NEW;
					end else if (!has_free) begin
						r.outcome = OC_TABLE_FULL;
					end else begin
						slot_used[free_slot] = 1'b1;
						slot_dest[free_slot] = e.dest_ip;
						slot_mask[free_slot] = e.dest_mask;
						slot_hop[free_slot] = gw;
						slot_metric[free_slot] = m;
						slot_garbage[free_slot] = 1'b0;
						changed_acc = 1'b1;
						r.route_slot = 6'(free_slot);
						r.outcome = OC_ADDED;
					end
				end else begin
					r.route_slot = 6'(hit);
					if (slot_hop[hit] == gw) begin
						if (slot_metric[hit] != m) begin
							slot_metric[hit] = m;
							changed = 1'b1;
						end
						if (m < METRIC_INF) begin
							slot_garbage[hit] = 1'b0;
						end else if (!slot_garbage[hit]) begin
							slot_garbage[hit] = 1'b1;
							changed = 1'b1;
						end
						r.outcome = changed ? OC_CHANGED : OC_REFRESHED;
					end else if (m < slot_metric[hit]) begin
						slot_metric[hit] = m;
						slot_hop[hit] = gw;
						slot_garbage[hit] = 1'b0;
						changed = 1'b1;
						r.outcome = OC_CHANGED;
					end else begin
						r.outcome = OC_WORSE;
					end
					if (changed)
						changed_acc = 1'b1;
				end
			end
			r.message_changed = changed_acc;
			r.last_result = e.last_of_message;
			if (e.last_of_message) begin
				entry_count = '0;
				changed_acc = 1'b0;
			end
			return r;
		endfunction

		function void note_entry(entry_beat_t e);
			pending_outcomes.push_back(apply_entry(e));
		endfunction

		function int unsigned pending();
			return pending_outcomes.size();
		endfunction

		function void check_result(result_beat_t got);
			result_beat_t want;
			if (pending_outcomes.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected result beat: outcome %0d slot %0d changed %0b last %0b",
						got.outcome, got.route_slot, got.message_changed, got.last_result);
				return;
			end
			want = pending_outcomes.pop_front();
			checked++;
			outcome_seen[want.outcome]++;
			if (got.outcome !== want.outcome || got.route_slot !== want.route_slot ||
				got.message_changed !== want.message_changed ||
				got.last_result !== want.last_result) begin
				faults++;
				if (faults <= 10)
					$display("result %0d mismatch: expected outcome %0d slot %0d changed %0b last %0b, got outcome %0d slot %0d changed %0b last %0b",
						checked, want.outcome, want.route_slot, want.message_changed,
						want.last_result, got.outcome, got.route_slot, got.message_changed,
						got.last_result);
			end
		endfunction
	endclass

endpackage

/* test/rip_route_table_update_unit_test.sv */
// rip_route_table_update_unit_test: self-checking bench for the rip v2 route table update unit
// depends on rrtu_pkg, rrtu_if, rrtu_mirror_pkg and the unit itself
`timescale 1ns / 1ps

module rip_route_table_update_unit_test;
	import rrtu_pkg::*;
	import rrtu_mirror_pkg::*;

	localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;
	localparam int MAX_ENTRIES = DEF_MAX_MESSAGE_ENTRIES;

	localparam int unsigned ITEMS = 1600;
	// the last stretch of beats runs with no idling on either side
	localparam int unsigned CALM_ITEMS = 150;
	// early half keeps to a small key set so the table never fills, later half overflows it
	localparam int unsigned KEY_POOL = 96;
	localparam int unsigned EARLY_KEYS = 40;
	// long receiver hold-off, started once this many beats have gone in
	localparam int unsigned HOLD_AT = 300;
	localparam int unsigned HOLD_CYCLES = 400;
	// covers a full scan plus short stalls; the hold-off dominates
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned TAIL_CYCLES = TABLE_DEPTH + 20;

	logic clk;
	logic arst_n;

	rrtu_entry_if  entry_ch ();
	rrtu_result_if result_ch ();

	rip_route_table_update_unit #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.MAX_MESSAGE_ENTRIES(MAX_ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.entry(entry_ch),
		.result(result_ch)
	);

	route_table_mirror board;

	// stimulus pools: route keys, neighbouring routers and explicit gateways
	logic [31:0] key_dest [KEY_POOL];
	logic [31:0] key_mask [KEY_POOL];
	logic [31:0] router_pool [4];
	logic [31:0] hop_pool [4];

	int unsigned sent;
	int unsigned messages;
	bit          calm;
	bit          held_off;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// offer one entry beat, perhaps after a short idle burst, and wait for it to go in;
	// valid is left high so back-to-back beats need no second assignment in one step
	task automatic send_entry(input entry_beat_t beat);
		calm = (sent >= ITEMS - CALM_ITEMS);
		if (!calm && $urandom_range(0, 7) == 0) begin
			entry_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		entry_ch.valid <= 1'b1;
		entry_ch.payload <= beat;
		@(posedge clk);
		while (entry_ch.ready !== 1'b1) @(posedge clk);
		board.note_entry(beat);
		sent++;
	endtask

	function automatic entry_beat_t make_entry(logic [15:0] family, logic [31:0] dest,
		logic [31:0] mask, logic [31:0] hop, logic [31:0] metric, logic [31:0] sender,
		bit last);
		entry_beat_t b;
		b.address_family = family;
		b.dest_ip = dest;
		b.dest_mask = mask;
		b.entry_gateway = hop;
		b.rx_metric = metric;
		b.sender_ip = sender;
		b.now_time = $urandom;
		b.last_of_message = last;
		return b;
	endfunction

	// mostly well-formed entries on a shared key set, with a tenth of noise
	function automatic entry_beat_t random_entry(int unsigned key_span, logic [31:0] sender,
		logic [31:0] stamp, bit last);
		entry_beat_t b;
		int unsigned k;
		k = $urandom_range(0, key_span - 1);
		b.address_family = RIP_FAMILY_IP;
		b.dest_ip = key_dest[k];
		b.dest_mask = key_mask[k];
		b.sender_ip = sender;
		b.now_time = stamp;
		b.last_of_message = last;
		// metrics near infinity are the interesting ones, so weight them up
		case ($urandom_range(0, 9))
			0: b.rx_metric = 32'd15;
			1: b.rx_metric = 32'd16;
			default: b.rx_metric = $urandom_range(1, 16);
		endcase
		// a zero gateway means the sender, which keeps same-router updates frequent
		case ($urandom_range(0, 3))
			0, 1: b.entry_gateway = '0;
			2: b.entry_gateway = router_pool[$urandom_range(0, 3)];
			default: b.entry_gateway = hop_pool[$urandom_range(0, 3)];
		endcase
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 3))
				0: b.address_family = 16'($urandom);
				1: b.rx_metric = $urandom;
				2: b.rx_metric = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom_range(17, 64);
				default: begin
					b.address_family = 16'($urandom);
					b.dest_ip = $urandom;
					b.dest_mask = $urandom;
					b.entry_gateway = $urandom;
					b.rx_metric = $urandom;
					b.sender_ip = $urandom;
				end
			endcase
		end
		return b;
	endfunction

	// short walk through every outcome but the message limit and a full table,
	// which the random part reaches on its own
	task automatic run_directed();
		logic [31:0] s1;
		logic [31:0] s2;
		logic [31:0] da;
		logic [31:0] ma;
		logic [31:0] db;
		logic [31:0] mb;
		s1 = router_pool[0];
		s2 = router_pool[1];
		da = 32'h0a01_0000;
		ma = 32'hffff_0000;
		db = 32'hc0a8_0100;
		mb = 32'hffff_ff00;
		// bad family at both ends of the field, then bad metrics
		send_entry(make_entry(16'h0000, da, ma, '0, 32'd1, s1, 1'b0));
		send_entry(make_entry(16'hffff, da, ma, '0, 32'd1, s1, 1'b0));
		send_entry(make_entry(RIP_FAMILY_IP, da, ma, '0, 32'd0, s1, 1'b0));
		send_entry(make_entry(RIP_FAMILY_IP, da, ma, '0, 32'd17, s1, 1'b0));
		send_entry(make_entry(RIP_FAMILY_IP, da, ma, '0, 32'hffff_ffff, s1, 1'b0));
		// new route, refresh, same-router metric change given by an explicit hop
		send_entry(make_entry(RIP_FAMILY_IP, da, ma, '0, 32'd1, s1, 1'b0));
		send_entry(make_entry(RIP_FAMILY_IP, da, ma, '0, 32'd1, s1, 1'b0));
		send_entry(make_entry(RIP_FAMILY_IP, da, ma, s1, 32'd4, s1, 1'b0));
		// same router goes to infinity, then stays there
		send_entry(make_entry(RIP_FAMILY_IP, da, ma, '0, 32'd16, s1, 1'b0));
		send_entry(make_entry(RIP_FAMILY_IP, da, ma, '0, 32'd16, s1, 1'b0));
		send_entry(make_entry(RIP_FAMILY_IP, da, ma, '0, 32'd15, s1, 1'b0));
		// another router with a better metric takes over, the old one is then worse
		send_entry(make_entry(RIP_FAMILY_IP, da, ma, '0, 32'd3, s2, 1'b0));
		send_entry(make_entry(RIP_FAMILY_IP, da, ma, '0, 32'd3, s1, 1'b0));
		send_entry(make_entry(RIP_FAMILY_IP, da, ma, '0, 32'd9, s1, 1'b0));
		// unreachable new route is dropped, a reachable one is added
		send_entry(make_entry(RIP_FAMILY_IP, db, mb, '0, 32'd16, s1, 1'b0));
		send_entry(make_entry(RIP_FAMILY_IP, db, mb, '0, 32'd15, s1, 1'b0));
		send_entry(make_entry(RIP_FAMILY_IP, db, mb, 32'hffff_ffff, 32'd14, s1, 1'b0));
		// all-zero and all-ones keys
		send_entry(make_entry(RIP_FAMILY_IP, '0, '0, '0, 32'd1, 32'hffff_ffff, 1'b0));
		send_entry(make_entry(RIP_FAMILY_IP, 32'hffff_ffff, 32'hffff_ffff, '0, 32'd1, s1, 1'b1));
		// a quiet message: the changed flag must start clear again
		send_entry(make_entry(RIP_FAMILY_IP, da, ma, '0, 32'd3, s2, 1'b0));
		send_entry(make_entry(16'h0001, da, ma, '0, 32'd3, s2, 1'b1));
		messages += 2;
	endtask

	// whole messages from one router each; some run past the per-message limit
	// and past the point where the entry counter saturates
	task automatic run_random();
		int unsigned len;
		int unsigned key_span;
		logic [31:0] sender;
		logic [31:0] stamp;
		while (sent < ITEMS) begin
			key_span = (sent < ITEMS / 2) ? EARLY_KEYS : KEY_POOL;
			case ($urandom_range(0, 9))
				0: len = $urandom_range(MAX_ENTRIES + 1, 40);
				1, 2: len = $urandom_range(1, 4);
				default: len = $urandom_range(5, MAX_ENTRIES);
			endcase
			sender = ($urandom_range(0, 15) == 0) ? $urandom : router_pool[$urandom_range(0, 3)];
			stamp = $urandom;
			for (int unsigned k = 1; k <= len; k++)
				send_entry(random_entry(key_span, sender, stamp, k == len));
			messages++;
		end
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		entry_ch.valid <= 1'b0;
		entry_ch.payload <= '0;
		sent = 0;
		messages = 0;
		calm = 1'b0;
		held_off = 1'b0;
		board = new(TABLE_DEPTH, MAX_ENTRIES);
		foreach (key_dest[i]) begin
			key_dest[i] = $urandom;
			key_mask[i] = $urandom;
		end
		foreach (router_pool[i]) begin
			router_pool[i] = $urandom;
			hop_pool[i] = $urandom;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		entry_ch.valid <= 1'b0;
		// drain, then give a late or spurious beat the time of one more scan to show up
		while (board.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d entries in %0d messages, %0d result beats checked",
			sent, messages, board.checked);
		$display("outcomes: bad family %0d, bad metric %0d, over limit %0d, added %0d, full %0d, unreachable %0d, changed %0d, refreshed %0d, worse %0d",
			board.outcome_seen[OC_BAD_FAMILY], board.outcome_seen[OC_BAD_METRIC],
			board.outcome_seen[OC_OVER_LIMIT], board.outcome_seen[OC_ADDED],
			board.outcome_seen[OC_TABLE_FULL], board.outcome_seen[OC_UNREACH_NEW],
			board.outcome_seen[OC_CHANGED], board.outcome_seen[OC_REFRESHED],
			board.outcome_seen[OC_WORSE]);
		if (board.faults == 0 && board.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d faults, %0d results outstanding", board.faults, board.pending());
			$display("Verification failed");
		end
		$finish;
	end

	// result side: random stall bursts, one long hold-off so the unit backs up
	// into its entry channel, and no stalls at all near the end
	initial begin : result_sink
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held_off && sent >= HOLD_AT) begin
				held_off = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
		end
	end

	// every result beat is checked against the oldest prediction
	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
			board.check_result(result_ch.payload);
	end

	// ends the run if no beat moves on either channel for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((entry_ch.valid === 1'b1 && entry_ch.ready === 1'b1) ||
				(result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no beat accepted in %0d cycles", WATCHDOG_LIMIT);
		$display("Verification failed");
		$finish;
	end

endmodule

/* rip_route_table_update_unit.f */
sv/rrtu_pkg.sv
sv/rrtu_if.sv
sv/rrtu_screen.sv
sv/rrtu_mem.sv
sv/rrtu_ctrl.sv
sv/rip_route_table_update_unit.sv
sv/rrtu_checker.sv
test/rrtu_mirror_pkg.sv
test/rip_route_table_update_unit_test.sv
